### rtl/vec2_pkg.sv
// ----------------------------------------------------------------------------
// vec2_pkg
// Opcodes, pipeline context and the 32-bit clamp shared by the vector unit.
// ----------------------------------------------------------------------------
package vec2_pkg;

  typedef enum logic [3:0] {
    OP_ADD   = 4'd0,
    OP_SUB   = 4'd1,
    OP_DOT   = 4'd2,
    OP_CROSS = 4'd3,
    OP_SCALE = 4'd4,
    OP_NEG   = 4'd5,
    OP_LEN   = 4'd6,
    OP_NORM  = 4'd7,
    OP_PROJ  = 4'd8
  } opcode_t;

  localparam int WIDE_W = 80;

  localparam logic [31:0] MAX32 = 32'h7FFF_FFFF;
  localparam logic [31:0] MIN32 = 32'h8000_0000;

  localparam logic signed [WIDE_W-1:0] WIDE_MAX = {48'h0, MAX32};
  localparam logic signed [WIDE_W-1:0] WIDE_MIN = {{48{1'b1}}, MIN32};

  typedef struct packed {
    logic        sat;
    logic [31:0] val;
  } clamp_t;

  // everything an item carries down the pipe besides the working values
  typedef struct packed {
    logic [3:0]         op;
    logic [31:0]        rx;
    logic [31:0]        ry;
    logic [31:0]        rs;
    logic               sat;
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic [31:0]        ux;
    logic [31:0]        uy;
    logic               sx;
    logic               sy;
    logic               zero;
    logic [31:0]        len;
  } ctx_t;

  function automatic clamp_t sat32(input logic signed [WIDE_W-1:0] v);
    clamp_t c;
    c.sat = 1'b0;
    c.val = v[31:0];
    if (v > WIDE_MAX) begin
      c.sat = 1'b1;
      c.val = MAX32;
    end else if (v < WIDE_MIN) begin
      c.sat = 1'b1;
      c.val = MIN32;
    end
    return c;
  endfunction

endpackage

### rtl/vec2_prep.sv
// ----------------------------------------------------------------------------
// vec2_prep
// Front end: input register, simple ops, products for dot/cross/scale,
// magnitude alignment and sum of squares for the square root.
// ----------------------------------------------------------------------------
module vec2_prep #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  logic [3:0]         in_opcode,
  input  logic signed [31:0] in_a_x,
  input  logic signed [31:0] in_a_y,
  input  logic signed [31:0] in_b_x,
  input  logic signed [31:0] in_b_y,
  input  logic signed [31:0] in_factor,
  output logic               v_out,
  output vec2_pkg::ctx_t     ctx_out,
  output logic [63:0]        sq_out
);

  // stage 1: input register
  logic               v1_r;
  logic [3:0]         op1_r;
  logic signed [31:0] ax1_r, ay1_r, bx1_r, by1_r, f1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op1_r <= in_opcode;
      ax1_r <= in_a_x;
      ay1_r <= in_a_y;
      bx1_r <= in_b_x;
      by1_r <= in_b_y;
      f1_r  <= in_factor;
    end
  end

  // stage 2: products, simple ops, magnitudes
  logic signed [31:0] mb0, mb1, vx, vy;
  logic signed [32:0] add_x, add_y, sub_x, sub_y, neg_x, neg_y;
  vec2_pkg::clamp_t   cx, cy;
  logic [31:0]        ux, uy;

  always_comb begin
    mb0 = f1_r;
    mb1 = f1_r;
    unique case (op1_r)
      vec2_pkg::OP_DOT: begin
        mb0 = bx1_r;
        mb1 = by1_r;
      end
      vec2_pkg::OP_CROSS: begin
        mb0 = by1_r;
        mb1 = bx1_r;
      end
      default: begin
      end
    endcase

    add_x = 33'(ax1_r) + 33'(bx1_r);
    add_y = 33'(ay1_r) + 33'(by1_r);
    sub_x = 33'(ax1_r) - 33'(bx1_r);
    sub_y = 33'(ay1_r) - 33'(by1_r);
    neg_x = -33'(ax1_r);
    neg_y = -33'(ay1_r);

    cx = '0;
    cy = '0;
    unique case (op1_r)
      vec2_pkg::OP_ADD: begin
        cx = vec2_pkg::sat32(80'(add_x));
        cy = vec2_pkg::sat32(80'(add_y));
      end
      vec2_pkg::OP_SUB: begin
        cx = vec2_pkg::sat32(80'(sub_x));
        cy = vec2_pkg::sat32(80'(sub_y));
      end
      vec2_pkg::OP_NEG: begin
        cx = vec2_pkg::sat32(80'(neg_x));
        cy = vec2_pkg::sat32(80'(neg_y));
      end
      default: begin
      end
    endcase

    // project normalizes B, everything else works on A
    vx = (op1_r == vec2_pkg::OP_PROJ) ? bx1_r : ax1_r;
    vy = (op1_r == vec2_pkg::OP_PROJ) ? by1_r : ay1_r;
    ux = vx[31] ? (~vx + 32'd1) : vx;
    uy = vy[31] ? (~vy + 32'd1) : vy;
  end

  logic               v2_r;
  logic [3:0]         op2_r;
  logic signed [63:0] p0_r, p1_r;
  logic [31:0]        rx2_r, ry2_r;
  logic               sat2_r;
  logic signed [31:0] ax2_r, ay2_r;
  logic [31:0]        ux2_r, uy2_r, m2_r;
  logic               sx2_r, sy2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op2_r  <= op1_r;
      p0_r   <= ax1_r * mb0;
      p1_r   <= ay1_r * mb1;
      rx2_r  <= cx.val;
      ry2_r  <= cy.val;
      sat2_r <= cx.sat | cy.sat;
      ax2_r  <= ax1_r;
      ay2_r  <= ay1_r;
      ux2_r  <= ux;
      uy2_r  <= uy;
      m2_r   <= (ux > uy) ? ux : uy;
      sx2_r  <= vx[31];
      sy2_r  <= vy[31];
    end
  end

  // stage 3: finish product ops, find alignment shift
  logic signed [64:0] psum, psum_sh, p0_sh, p1_sh;
  vec2_pkg::clamp_t   cs, ex, ey;
  logic [4:0]         pos, t_nxt;
  logic               pow2;
  vec2_pkg::ctx_t     ctx3_nxt;

  always_comb begin
    psum    = (op2_r == vec2_pkg::OP_CROSS) ? (65'(p0_r) - 65'(p1_r))
                                            : (65'(p0_r) + 65'(p1_r));
    psum_sh = psum >>> FRAC_BITS;
    p0_sh   = 65'(p0_r) >>> FRAC_BITS;
    p1_sh   = 65'(p1_r) >>> FRAC_BITS;
    cs      = vec2_pkg::sat32(80'(psum_sh));
    ex      = vec2_pkg::sat32(80'(p0_sh));
    ey      = vec2_pkg::sat32(80'(p1_sh));

    pos = '0;
    for (int i = 0; i < 32; i++) begin
      if (m2_r[i]) pos = 5'(i);
    end
    pow2  = (m2_r & (m2_r - 32'd1)) == 32'd0;
    // largest shift that keeps the bigger magnitude at or below 2^31
    t_nxt = 5'd31 - pos - {4'd0, !pow2};
    if (op2_r == vec2_pkg::OP_LEN) t_nxt = '0;

    ctx3_nxt      = '0;
    ctx3_nxt.op   = op2_r;
    ctx3_nxt.ax   = ax2_r;
    ctx3_nxt.ay   = ay2_r;
    ctx3_nxt.ux   = ux2_r;
    ctx3_nxt.uy   = uy2_r;
    ctx3_nxt.sx   = sx2_r;
    ctx3_nxt.sy   = sy2_r;
    ctx3_nxt.zero = (m2_r == 32'd0);
    unique case (op2_r)
      vec2_pkg::OP_ADD, vec2_pkg::OP_SUB, vec2_pkg::OP_NEG: begin
        ctx3_nxt.rx  = rx2_r;
        ctx3_nxt.ry  = ry2_r;
        ctx3_nxt.sat = sat2_r;
      end
      vec2_pkg::OP_DOT, vec2_pkg::OP_CROSS: begin
        ctx3_nxt.rs  = cs.val;
        ctx3_nxt.sat = cs.sat;
      end
      vec2_pkg::OP_SCALE: begin
        ctx3_nxt.rx  = ex.val;
        ctx3_nxt.ry  = ey.val;
        ctx3_nxt.sat = ex.sat | ey.sat;
      end
      default: begin
      end
    endcase
  end

  logic           v3_r, v4_r, v5_r, v6_r;
  vec2_pkg::ctx_t ctx3_r, ctx4_r, ctx5_r, ctx6_r;
  logic [4:0]     t3_r;
  logic [63:0]    sqx5_r, sqy5_r, sq6_r;
  vec2_pkg::ctx_t ctx4_nxt;

  always_comb begin
    ctx4_nxt    = ctx3_r;
    ctx4_nxt.ux = ctx3_r.ux << t3_r;
    ctx4_nxt.uy = ctx3_r.uy << t3_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctx3_r <= ctx3_nxt;
      t3_r   <= t_nxt;
      ctx4_r <= ctx4_nxt;
      sqx5_r <= ctx4_r.ux * ctx4_r.ux;
      sqy5_r <= ctx4_r.uy * ctx4_r.uy;
      ctx5_r <= ctx4_r;
      sq6_r  <= sqx5_r + sqy5_r;
      ctx6_r <= ctx5_r;
    end
  end

  assign v_out   = v6_r;
  assign ctx_out = ctx6_r;
  assign sq_out  = sq6_r;

endmodule

### rtl/vec2_sqrt.sv
// ----------------------------------------------------------------------------
// vec2_sqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module vec2_sqrt (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           v_in,
  input  vec2_pkg::ctx_t ctx_in,
  input  logic [63:0]    n_in,
  output logic           v_out,
  output vec2_pkg::ctx_t ctx_out
);

  localparam int STEPS = 32;

  logic           v_r    [STEPS];
  vec2_pkg::ctx_t ctx_r  [STEPS];
  logic [63:0]    n_r    [STEPS];
  logic [33:0]    rem_r  [STEPS];
  logic [31:0]    root_r [STEPS];

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    logic           v_prev;
    vec2_pkg::ctx_t ctx_prev;
    logic [63:0]    n_prev;
    logic [33:0]    rem_prev;
    logic [31:0]    root_prev;
    logic [35:0]    rem_sh, trial;
    logic [33:0]    rem_nxt;
    logic [31:0]    root_nxt;

    if (i == 0) begin : g_first
      assign v_prev    = v_in;
      assign ctx_prev  = ctx_in;
      assign n_prev    = n_in;
      assign rem_prev  = '0;
      assign root_prev = '0;
    end else begin : g_next
      assign v_prev    = v_r[i-1];
      assign ctx_prev  = ctx_r[i-1];
      assign n_prev    = n_r[i-1];
      assign rem_prev  = rem_r[i-1];
      assign root_prev = root_r[i-1];
    end

    always_comb begin
      rem_sh = {rem_prev, n_prev[63:62]};
      trial  = {2'b00, root_prev, 2'b01};
      if (rem_sh >= trial) begin
        rem_nxt  = 34'(rem_sh - trial);
        root_nxt = {root_prev[30:0], 1'b1};
      end else begin
        rem_nxt  = rem_sh[33:0];
        root_nxt = {root_prev[30:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (en) begin
        v_r[i] <= v_prev;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ctx_r[i]  <= ctx_prev;
        n_r[i]    <= {n_prev[61:0], 2'b00};
        rem_r[i]  <= rem_nxt;
        root_r[i] <= root_nxt;
      end
    end
  end

  always_comb begin
    ctx_out     = ctx_r[STEPS-1];
    ctx_out.len = root_r[STEPS-1];
  end

  assign v_out = v_r[STEPS-1];

endmodule

### rtl/vec2_div.sv
// ----------------------------------------------------------------------------
// vec2_div
// Pipelined restoring divider: aligned magnitudes over the vector length,
// one quotient bit per stage for both components.
// ----------------------------------------------------------------------------
module vec2_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               v_in,
  input  vec2_pkg::ctx_t     ctx_in,
  output logic               v_out,
  output vec2_pkg::ctx_t     ctx_out,
  output logic [FRAC_BITS:0] qx_out,
  output logic [FRAC_BITS:0] qy_out
);

  localparam int QW = FRAC_BITS + 1;

  logic           v_r   [QW];
  vec2_pkg::ctx_t ctx_r [QW];
  logic [31:0]    remx_r[QW];
  logic [31:0]    remy_r[QW];
  logic [QW-1:0]  qx_r  [QW];
  logic [QW-1:0]  qy_r  [QW];

  for (genvar i = 0; i < QW; i++) begin : g_step
    logic           v_prev;
    vec2_pkg::ctx_t ctx_prev;
    logic [32:0]    shx, shy, dv;
    logic [QW-1:0]  qx_prev, qy_prev;
    logic           gex, gey;
    logic [31:0]    remx_nxt, remy_nxt;

    // the length is never below either aligned component, so the first
    // quotient bit comes straight from the magnitude
    if (i == 0) begin : g_first
      assign v_prev   = v_in;
      assign ctx_prev = ctx_in;
      assign shx      = {1'b0, ctx_in.ux};
      assign shy      = {1'b0, ctx_in.uy};
      assign qx_prev  = '0;
      assign qy_prev  = '0;
    end else begin : g_next
      assign v_prev   = v_r[i-1];
      assign ctx_prev = ctx_r[i-1];
      assign shx      = {remx_r[i-1], 1'b0};
      assign shy      = {remy_r[i-1], 1'b0};
      assign qx_prev  = qx_r[i-1];
      assign qy_prev  = qy_r[i-1];
    end

    always_comb begin
      dv       = {1'b0, ctx_prev.len};
      gex      = shx >= dv;
      gey      = shy >= dv;
      remx_nxt = gex ? 32'(shx - dv) : shx[31:0];
      remy_nxt = gey ? 32'(shy - dv) : shy[31:0];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (en) begin
        v_r[i] <= v_prev;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ctx_r[i]  <= ctx_prev;
        remx_r[i] <= remx_nxt;
        remy_r[i] <= remy_nxt;
        qx_r[i]   <= {qx_prev[QW-2:0], gex};
        qy_r[i]   <= {qy_prev[QW-2:0], gey};
      end
    end
  end

  assign v_out   = v_r[QW-1];
  assign ctx_out = ctx_r[QW-1];
  assign qx_out  = qx_r[QW-1];
  assign qy_out  = qy_r[QW-1];

endmodule

### rtl/vec2_post.sv
// ----------------------------------------------------------------------------
// vec2_post
// Back end: signs the unit vector, runs the projection products and
// picks the result; its last stage is the output register.
// ----------------------------------------------------------------------------
module vec2_post #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               v_in,
  input  vec2_pkg::ctx_t     ctx_in,
  input  logic [FRAC_BITS:0] qx_in,
  input  logic [FRAC_BITS:0] qy_in,
  output logic               out_valid,
  output logic [31:0]        out_x,
  output logic [31:0]        out_y,
  output logic [31:0]        out_scalar,
  output logic               out_saturated
);

  localparam int NW = FRAC_BITS + 2;
  localparam int PW = NW + 32;
  localparam int SW = 35;
  localparam int RW = NW + SW;

  // stage 1: signed unit vector and first products
  logic signed [NW-1:0] nx, ny;

  always_comb begin
    nx = ctx_in.sx ? -$signed({1'b0, qx_in}) : $signed({1'b0, qx_in});
    ny = ctx_in.sy ? -$signed({1'b0, qy_in}) : $signed({1'b0, qy_in});
    if (ctx_in.zero) begin
      nx = '0;
      ny = '0;
    end
  end

  logic                 v1_r, v2_r, v3_r;
  vec2_pkg::ctx_t       ctx1_r, ctx2_r, ctx3_r;
  logic signed [NW-1:0] nx1_r, ny1_r, nx2_r, ny2_r, nx3_r, ny3_r;
  logic signed [PW-1:0] pa1_r, pb1_r;
  logic signed [SW-1:0] s2_r;
  logic signed [RW-1:0] rx3_r, ry3_r;

  // stage 2: floor of the dot product with the unit vector
  logic signed [PW:0]   dsum, dsh;

  always_comb begin
    dsum = (PW+1)'(pa1_r) + (PW+1)'(pb1_r);
    dsh  = dsum >>> FRAC_BITS;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= v_in;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctx1_r <= ctx_in;
      nx1_r  <= nx;
      ny1_r  <= ny;
      pa1_r  <= nx * ctx_in.ax;
      pb1_r  <= ny * ctx_in.ay;
      ctx2_r <= ctx1_r;
      nx2_r  <= nx1_r;
      ny2_r  <= ny1_r;
      s2_r   <= dsh[SW-1:0];
      ctx3_r <= ctx2_r;
      nx3_r  <= nx2_r;
      ny3_r  <= ny2_r;
      rx3_r  <= nx2_r * s2_r;
      ry3_r  <= ny2_r * s2_r;
    end
  end

  // stage 4: scale back, clamp, choose the result
  logic signed [RW-1:0] rx_sh, ry_sh;
  vec2_pkg::clamp_t     cx, cy;
  logic [31:0]          x_nxt, y_nxt, s_nxt;
  logic                 sat_nxt;

  always_comb begin
    rx_sh   = rx3_r >>> FRAC_BITS;
    ry_sh   = ry3_r >>> FRAC_BITS;
    cx      = vec2_pkg::sat32(80'(rx_sh));
    cy      = vec2_pkg::sat32(80'(ry_sh));
    x_nxt   = ctx3_r.rx;
    y_nxt   = ctx3_r.ry;
    s_nxt   = ctx3_r.rs;
    sat_nxt = ctx3_r.sat;
    unique case (ctx3_r.op)
      vec2_pkg::OP_NORM: begin
        x_nxt   = 32'(nx3_r);
        y_nxt   = 32'(ny3_r);
        sat_nxt = 1'b0;
      end
      vec2_pkg::OP_PROJ: begin
        x_nxt   = cx.val;
        y_nxt   = cy.val;
        sat_nxt = cx.sat | cy.sat;
      end
      vec2_pkg::OP_LEN: begin
        s_nxt   = ctx3_r.len[31] ? vec2_pkg::MAX32 : ctx3_r.len;
        sat_nxt = ctx3_r.len[31];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_x         <= x_nxt;
      out_y         <= y_nxt;
      out_scalar    <= s_nxt;
      out_saturated <= sat_nxt;
    end
  end

endmodule

### rtl/vec2_alu_top.sv
// ----------------------------------------------------------------------------
// vec2_alu_top
// Two-dimensional vector unit in signed fixed point, fully pipelined.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  in_     | input     | in_valid / in_stall | opcode, a_x, a_y, b_x, b_y, factor
//  out_    | output    | out_valid/out_stall | x, y, scalar, saturated
//
//  one request per cycle while the pipe is not stalled; it has 6 front stages,
//  32 square root stages, FRAC_BITS + 1 divider stages, 4 back stages
//  every opcode takes the same path, so results leave in request order
//  out_stall with a waiting result freezes the whole pipe and raises in_stall
//  synchronous reset clears the valid bits only
// ----------------------------------------------------------------------------
module vec2_alu_top #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [3:0]         in_opcode,
  input  logic signed [31:0] in_a_x,
  input  logic signed [31:0] in_a_y,
  input  logic signed [31:0] in_b_x,
  input  logic signed [31:0] in_b_y,
  input  logic signed [31:0] in_factor,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_scalar,
  output logic               out_saturated
);

  logic               en;
  logic               prep_v, sqrt_v, div_v;
  vec2_pkg::ctx_t     prep_ctx, sqrt_ctx, div_ctx;
  logic [63:0]        prep_sq;
  logic [FRAC_BITS:0] qx, qy;

  assign in_stall = out_valid && out_stall;
  assign en       = !in_stall;

  vec2_prep #(.FRAC_BITS(FRAC_BITS)) u_prep (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_valid),
    .in_opcode (in_opcode),
    .in_a_x    (in_a_x),
    .in_a_y    (in_a_y),
    .in_b_x    (in_b_x),
    .in_b_y    (in_b_y),
    .in_factor (in_factor),
    .v_out     (prep_v),
    .ctx_out   (prep_ctx),
    .sq_out    (prep_sq)
  );

  vec2_sqrt u_sqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .v_in    (prep_v),
    .ctx_in  (prep_ctx),
    .n_in    (prep_sq),
    .v_out   (sqrt_v),
    .ctx_out (sqrt_ctx)
  );

  vec2_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .v_in    (sqrt_v),
    .ctx_in  (sqrt_ctx),
    .v_out   (div_v),
    .ctx_out (div_ctx),
    .qx_out  (qx),
    .qy_out  (qy)
  );

  vec2_post #(.FRAC_BITS(FRAC_BITS)) u_post (
    .clk           (clk),
    .rst_n         (rst_n),
    .en            (en),
    .v_in          (div_v),
    .ctx_in        (div_ctx),
    .qx_in         (qx),
    .qy_in         (qy),
    .out_valid     (out_valid),
    .out_x         (out_x),
    .out_y         (out_y),
    .out_scalar    (out_scalar),
    .out_saturated (out_saturated)
  );

endmodule

### rtl/vec2_chk.sv
// ----------------------------------------------------------------------------
// vec2_chk
// Port-level checks for the vector unit, bound to the top level.
// ----------------------------------------------------------------------------
module vec2_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_x,
  input logic [31:0] out_y,
  input logic [31:0] out_scalar,
  input logic        out_saturated
);

  // input side only backs up behind a held result
  a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("in_stall does not follow the held output");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_x) && $stable(out_y)
      && $stable(out_scalar) && $stable(out_saturated))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present right after reset");

  // scalar and vector results never share a request
  a_scalar_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_scalar != 32'd0 |-> out_x == 32'd0 && out_y == 32'd0)
    else $error("scalar and vector fields both nonzero");

  a_sat_extreme: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated |->
      out_x == vec2_pkg::MAX32 || out_x == vec2_pkg::MIN32 ||
      out_y == vec2_pkg::MAX32 || out_y == vec2_pkg::MIN32 ||
      out_scalar == vec2_pkg::MAX32 || out_scalar == vec2_pkg::MIN32)
    else $error("saturated flag without a clamped field");

endmodule

bind vec2_alu_top vec2_chk u_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_x         (out_x),
  .out_y         (out_y),
  .out_scalar    (out_scalar),
  .out_saturated (out_saturated)
);
